// ===== src/fifo_token_bucket_shaper_unit_defines.svh =====
// Assertion macros used by the shaper's sequencer.
`ifndef FIFO_TOKEN_BUCKET_SHAPER_UNIT_DEFINES_SVH
`define FIFO_TOKEN_BUCKET_SHAPER_UNIT_DEFINES_SVH

// Antecedent holds in this cycle, consequent must hold in the same cycle.
`define FTBS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent holds in this cycle, consequent must hold in the next cycle.
`define FTBS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/ftbs_pkg.sv =====
// ---------------------------------------------------------------------------
// ftbs_pkg
// Types and constants shared by the token bucket shaper.
// ---------------------------------------------------------------------------
package ftbs_pkg;

   localparam int MAX_RESULTS = 16;
   localparam int RES_CNT_W   = 5;

   typedef enum logic [1:0] {
      CMD_REQUEST = 2'd0,
      CMD_TICK    = 2'd1,
      CMD_STOP    = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_GRANTED  = 2'd0,
      ST_PASSED   = 2'd1,
      ST_RELEASED = 2'd2,
      ST_REFUSED  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_REFILL_ADD,
      S_REFILL,
      S_RELEASE,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [7:0]  tag;
      logic [31:0] remaining;
   } entry_type;

   typedef struct packed {
      logic        shift;
      logic        load;
      logic        trim;
      entry_type   load_entry;
      logic [31:0] trim_rem;
   } chain_ctl_type;

endpackage

// ===== src/ftbs_if.sv =====
// ---------------------------------------------------------------------------
// ftbs_if
// Request and response channels of the token bucket shaper.
// ---------------------------------------------------------------------------
interface ftbs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [31:0] request_bytes;
   logic [7:0]  request_tag;

   modport source (output valid, command, request_bytes, request_tag, input ready);
   modport sink   (input valid, command, request_bytes, request_tag, output ready);
endinterface

interface ftbs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] grant_tag;
   logic [1:0] grant_status;
   logic       last_result;

   modport source (output valid, grant_tag, grant_status, last_result, input ready);
   modport sink   (input valid, grant_tag, grant_status, last_result, output ready);
endinterface

// ===== src/fifo_token_bucket_shaper_unit.sv =====
// ---------------------------------------------------------------------------
// fifo_token_bucket_shaper_unit
// Byte-rate shaper: a token bucket in front of a queue of waiting requests.
// ---------------------------------------------------------------------------
// Usage: words arrive on req_chan (request, refill tick or stop) and results
// leave on rsp_chan, each with a tag, a status and a last marker on the final
// result of the word. csr_write_en loads the refill amount, which the user must
// write only while the block is idle; the block itself does not enforce this.
// A word that walks no queue entries passes the decide and finish states. A
// stop, or a request or tick that arrives while stopped, passes decide, release
// and finish, one released waiter at a time. A refill pass runs decide, refill
// add, refill and finish, up to 16 results, popping one waiter per cycle unless stalled.
// A new word is taken only once the previous one has handed its last result
// to the output register. Reset clears the balance, the queue count and the
// stop flag; there is no clearing pass. When the receiver stalls, the output
// register and one held result fill up and the sequencer waits in place.
// ---------------------------------------------------------------------------
module fifo_token_bucket_shaper_unit
   import ftbs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [31:0] csr_write_data,
   ftbs_req_if.sink    req_chan,
   ftbs_rsp_if.source  rsp_chan
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   chain_ctl_type ctl;
   logic [CW-1:0] count;
   entry_type     cells [QUEUE_DEPTH];

   ftbs_ctrl #(.DEPTH(QUEUE_DEPTH), .CW(CW)) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .in_valid       (req_chan.valid),
      .in_ready       (req_chan.ready),
      .in_command     (req_chan.command),
      .in_bytes       (req_chan.request_bytes),
      .in_tag         (req_chan.request_tag),
      .out_valid      (rsp_chan.valid),
      .out_ready      (rsp_chan.ready),
      .out_tag        (rsp_chan.grant_tag),
      .out_status     (rsp_chan.grant_status),
      .out_last       (rsp_chan.last_result),
      .head           (cells[0]),
      .count          (count),
      .ctl            (ctl)
   );

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type nxt;
      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign nxt = '0;
      end else begin : g_mid
         assign nxt = cells[i+1];
      end
      ftbs_cell u_cell (
         .clock   (clock),
         .ctl     (ctl),
         .sel     (count == CW'(i)),
         .is_head (i == 0),
         .nxt     (nxt),
         .data    (cells[i])
      );
   end

endmodule

// ===== src/ftbs_cell.sv =====
// ---------------------------------------------------------------------------
// ftbs_cell
// One waiter slot of the queue chain; shifts towards the head on a pop.
// ---------------------------------------------------------------------------
module ftbs_cell
   import ftbs_pkg::*;
(
   input  logic          clock,
   input  chain_ctl_type ctl,
   input  logic          sel,
   input  logic          is_head,
   input  entry_type     nxt,
   output entry_type     data
);

   entry_type data_ff, data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.shift) begin
         data_in = nxt;
      end else if (ctl.load && sel) begin
         data_in = ctl.load_entry;
      end else if (ctl.trim && is_head) begin
         data_in.remaining = ctl.trim_rem;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== src/ftbs_ctrl.sv =====
// ---------------------------------------------------------------------------
// ftbs_ctrl
// Sequencer of the shaper: bucket balance, queue count and result staging.
// ---------------------------------------------------------------------------
`include "fifo_token_bucket_shaper_unit_defines.svh"

module ftbs_ctrl
   import ftbs_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write_en,
   input  logic [31:0]   csr_write_data,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [1:0]    in_command,
   input  logic [31:0]   in_bytes,
   input  logic [7:0]    in_tag,
   output logic          out_valid,
   input  logic          out_ready,
   output logic [7:0]    out_tag,
   output logic [1:0]    out_status,
   output logic          out_last,
   input  entry_type     head,
   output logic [CW-1:0] count,
   output chain_ctl_type ctl
);

   state_type state_ff, state_in;
   logic [1:0]           cmd_ff, cmd_in;
   logic [31:0]          bytes_ff, bytes_in;
   logic [7:0]           tag_ff, tag_in;
   logic [31:0]          refill_ff;
   logic [32:0]          balance_ff, balance_in;
   logic                 primed_ff, primed_in;
   logic                 due_ff, due_in;
   logic                 stopped_ff, stopped_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [RES_CNT_W-1:0] n_ff, n_in;
   logic [RES_CNT_W-1:0] budget_ff, budget_in;
   logic                 own_ff, own_in;
   logic                 held_valid_ff, held_valid_in;
   logic [7:0]           held_tag_ff, held_tag_in;
   logic [1:0]           held_status_ff, held_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_tag_ff, rsp_tag_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic        out_free, can_emit, accept;
   logic [32:0] bal_start;
   logic        head_short, refill_done, release_done;
   logic        e_do;
   logic [7:0]  e_tag;
   logic [1:0]  e_status;

   assign out_free     = !rsp_valid_ff || out_ready;
   assign can_emit     = !held_valid_ff || out_free;
   assign accept       = in_valid && in_ready;
   assign bal_start    = primed_ff ? balance_ff : {1'b0, refill_ff};
   assign head_short   = balance_ff < {1'b0, head.remaining};
   assign refill_done  = (count_ff == '0) || (n_ff == RES_CNT_W'(MAX_RESULTS));
   assign release_done = (count_ff == '0) || (n_ff == budget_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            case (cmd_ff)
               CMD_REQUEST: begin
                  if (stopped_ff) begin
                     state_in = S_RELEASE;
                  end else if (refill_ff != '0 && bal_start < {1'b0, bytes_ff}
                               && count_ff != CW'(DEPTH) && due_ff) begin
                     state_in = S_REFILL_ADD;
                  end else begin
                     state_in = S_FINISH;
                  end
               end
               CMD_TICK: begin
                  if (stopped_ff)              state_in = S_RELEASE;
                  else if (count_ff == '0)     state_in = S_FINISH;
                  else                         state_in = S_REFILL_ADD;
               end
               CMD_STOP: state_in = S_RELEASE;
               default:  state_in = S_FINISH;
            endcase
         end
         S_REFILL_ADD: state_in = S_REFILL;
         S_REFILL: begin
            if (refill_done) state_in = S_FINISH;
            else if (can_emit && head_short) state_in = S_FINISH;
         end
         S_RELEASE: begin
            if (release_done && (!own_ff || can_emit)) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!held_valid_ff || out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      cmd_in         = cmd_ff;
      bytes_in       = bytes_ff;
      tag_in         = tag_ff;
      balance_in     = balance_ff;
      primed_in      = primed_ff;
      due_in         = due_ff;
      stopped_in     = stopped_ff;
      count_in       = count_ff;
      n_in           = n_ff;
      budget_in      = budget_ff;
      own_in         = own_ff;
      held_valid_in  = held_valid_ff;
      held_tag_in    = held_tag_ff;
      held_status_in = held_status_ff;
      rsp_valid_in   = rsp_valid_ff && !out_ready;
      rsp_tag_in     = rsp_tag_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_last_in    = rsp_last_ff;
      ctl            = '0;
      e_do           = 1'b0;
      e_tag          = tag_ff;
      e_status       = ST_GRANTED;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in   = in_command;
               bytes_in = in_bytes;
               tag_in   = in_tag;
               n_in     = '0;
               own_in   = 1'b0;
            end
         end
         S_DECIDE: begin
            case (cmd_ff)
               CMD_REQUEST: begin
                  if (stopped_ff) begin
                     budget_in = RES_CNT_W'(MAX_RESULTS - 1);
                     own_in    = 1'b1;
                  end else if (refill_ff == '0) begin
                     e_do = 1'b1; e_status = ST_PASSED;
                  end else begin
                     primed_in = 1'b1;
                     if (bal_start >= {1'b0, bytes_ff}) begin
                        balance_in = bal_start - {1'b0, bytes_ff};
                        e_do = 1'b1; e_status = ST_GRANTED;
                     end else if (count_ff == CW'(DEPTH)) begin
                        balance_in = bal_start;
                        e_do = 1'b1; e_status = ST_REFUSED;
                     end else begin
                        balance_in                = bal_start;
                        ctl.load                  = 1'b1;
                        ctl.load_entry.tag        = tag_ff;
                        ctl.load_entry.remaining  = bytes_ff;
                        count_in                  = count_ff + 1'b1;
                        due_in                    = 1'b0;
                     end
                  end
               end
               CMD_TICK: begin
                  if (stopped_ff) begin
                     budget_in = RES_CNT_W'(MAX_RESULTS);
                  end else if (count_ff == '0) begin
                     due_in = 1'b1;
                  end
               end
               CMD_STOP: begin
                  stopped_in = 1'b1;
                  budget_in  = RES_CNT_W'(MAX_RESULTS);
               end
               default: ;
            endcase
         end
         S_REFILL_ADD: begin
            if (balance_ff < {1'b0, refill_ff}) balance_in = balance_ff + {1'b0, refill_ff};
         end
         S_REFILL: begin
            if (!refill_done && can_emit) begin
               if (head_short) begin
                  ctl.trim     = 1'b1;
                  ctl.trim_rem = head.remaining - balance_ff[31:0];
                  balance_in   = '0;
               end else begin
                  balance_in = balance_ff - {1'b0, head.remaining};
                  ctl.shift  = 1'b1;
                  count_in   = count_ff - 1'b1;
                  e_do = 1'b1; e_tag = head.tag; e_status = ST_GRANTED;
               end
            end
         end
         S_RELEASE: begin
            if (can_emit) begin
               if (!release_done) begin
                  ctl.shift = 1'b1;
                  count_in  = count_ff - 1'b1;
                  e_do = 1'b1; e_tag = head.tag; e_status = ST_RELEASED;
               end else if (own_ff) begin
                  e_do = 1'b1; e_status = ST_PASSED;
               end
            end
         end
         S_FINISH: begin
            if (held_valid_ff && out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_tag_in    = held_tag_ff;
               rsp_status_in = held_status_ff;
               rsp_last_in   = 1'b1;
               held_valid_in = 1'b0;
            end
         end
         default: ;
      endcase

      // A new result pushes the one held back out; only the final one is marked last.
      if (e_do) begin
         if (held_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_tag_in    = held_tag_ff;
            rsp_status_in = held_status_ff;
            rsp_last_in   = 1'b0;
         end
         held_valid_in  = 1'b1;
         held_tag_in    = e_tag;
         held_status_in = e_status;
         n_in           = n_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         refill_ff     <= '0;
         balance_ff    <= '0;
         primed_ff     <= 1'b0;
         due_ff        <= 1'b0;
         stopped_ff    <= 1'b0;
         count_ff      <= '0;
         n_ff          <= '0;
         own_ff        <= 1'b0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         if (csr_write_en) refill_ff <= csr_write_data;
         balance_ff    <= balance_in;
         primed_ff     <= primed_in;
         due_ff        <= due_in;
         stopped_ff    <= stopped_in;
         count_ff      <= count_in;
         n_ff          <= n_in;
         own_ff        <= own_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cmd_ff         <= cmd_in;
      bytes_ff       <= bytes_in;
      tag_ff         <= tag_in;
      budget_ff      <= budget_in;
      held_tag_ff    <= held_tag_in;
      held_status_ff <= held_status_in;
      rsp_tag_ff     <= rsp_tag_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign in_ready   = (state_ff == S_IDLE);
   assign out_valid  = rsp_valid_ff;
   assign out_tag    = rsp_tag_ff;
   assign out_status = rsp_status_ff;
   assign out_last   = rsp_last_ff;
   assign count      = count_ff;

   `FTBS_ASSERT_NOW(a_count_range, clock, reset, 1'b1, count_ff <= CW'(DEPTH), "queue count beyond depth")
   `FTBS_ASSERT_NOW(a_result_limit, clock, reset, 1'b1, n_ff <= RES_CNT_W'(MAX_RESULTS), "too many results for one word")
   `FTBS_ASSERT_NOW(a_idle_clean, clock, reset, state_ff == S_IDLE, !held_valid_ff, "held result left while idle")
   `FTBS_ASSERT_NEXT(a_stop_sticky, clock, reset, stopped_ff, stopped_ff, "stop cleared without reset")

endmodule

// ===== tb/fifo_token_bucket_shaper_unit_checker.sv =====
// ---------------------------------------------------------------------------
// fifo_token_bucket_shaper_unit_checker
// Watches the request and response channels and the refill register writes,
// predicts the grants of the shaper and compares every response word.
// ---------------------------------------------------------------------------
module fifo_token_bucket_shaper_unit_checker
   import ftbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [31:0] csr_write_data,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_bytes,
   input  logic [7:0]  req_tag,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_tag,
   input  logic [1:0]  rsp_status,
   input  logic        rsp_last,
   output int          failures,
   output int          grants_waiting
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 16;
   localparam int RING  = 64;

   typedef struct packed {
      logic [7:0] tag;
      status_type status;
      logic       last;
   } grant_type;

   grant_type    grant_ring[RING];
   int           ring_wr;
   int           ring_rd;
   logic [31:0]  refill;
   logic [32:0]  bucket;
   logic         primed;
   logic [7:0]   wait_tag[DEPTH];
   logic [32:0]  wait_rem[DEPTH];
   int           head;
   int           count;
   logic         refill_due;
   logic         stopped;
   grant_type    word_grants[MAX_RESULTS];
   int           word_n;

   initial begin
      failures = 0;
      ring_wr  = 0;
      ring_rd  = 0;
   end

   assign grants_waiting = ring_wr - ring_rd;

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $time, what);
      failures++;
   endtask

   function automatic void add_grant(input logic [7:0] tag, input status_type st);
      grant_type g;
      g.tag = tag;
      g.status = st;
      g.last = 1'b0;
      word_grants[word_n] = g;
      word_n++;
   endfunction

   function automatic void pop_waiter();
      head = (head + 1) % DEPTH;
      count--;
   endfunction

   function automatic void release_all(input int budget);
      while (count > 0 && word_n < budget) begin
         add_grant(wait_tag[head], ST_RELEASED);
         pop_waiter();
      end
   endfunction

   function automatic void refill_pass();
      if (bucket < {1'b0, refill}) bucket = bucket + {1'b0, refill};
      while (count > 0 && word_n < MAX_RESULTS) begin
         if (bucket < wait_rem[head]) begin
            wait_rem[head] = wait_rem[head] - bucket;
            bucket = '0;
            break;
         end
         bucket = bucket - wait_rem[head];
         add_grant(wait_tag[head], ST_GRANTED);
         pop_waiter();
      end
   endfunction

   function automatic void predict_word(input cmd_type cmd, input logic [31:0] bytes,
                                        input logic [7:0] tag);
      int slot;
      word_n = 0;
      case (cmd)
         CMD_REQUEST: begin
            if (stopped) begin
               release_all(MAX_RESULTS - 1);
               add_grant(tag, ST_PASSED);
            end else if (refill == '0) begin
               add_grant(tag, ST_PASSED);
            end else begin
               if (!primed) begin
                  bucket = {1'b0, refill};
                  primed = 1'b1;
               end
               if (bucket >= {1'b0, bytes}) begin
                  bucket = bucket - {1'b0, bytes};
                  add_grant(tag, ST_GRANTED);
               end else if (count >= DEPTH) begin
                  add_grant(tag, ST_REFUSED);
               end else begin
                  slot = (head + count) % DEPTH;
                  wait_tag[slot] = tag;
                  wait_rem[slot] = {1'b0, bytes};
                  count++;
                  if (refill_due) begin
                     refill_due = 1'b0;
                     refill_pass();
                  end
               end
            end
         end
         CMD_TICK: begin
            if (stopped) release_all(MAX_RESULTS);
            else if (count == 0) refill_due = 1'b1;
            else refill_pass();
         end
         CMD_STOP: begin
            stopped = 1'b1;
            release_all(MAX_RESULTS);
         end
         default: ;
      endcase
      if (word_n > 0) word_grants[word_n - 1].last = 1'b1;
      for (int i = 0; i < word_n; i++) begin
         grant_ring[ring_wr % RING] = word_grants[i];
         ring_wr++;
      end
   endfunction

   always @(posedge clock) begin
      grant_type g;
      if (reset) begin
         failures = 0;
         ring_wr = 0;
         ring_rd = 0;
         refill = '0;
         bucket = '0;
         primed = 1'b0;
         head = 0;
         count = 0;
         refill_due = 1'b0;
         stopped = 1'b0;
      end else begin
         if (csr_write_en) refill = csr_write_data;
         if (req_valid && req_ready) predict_word(cmd_type'(req_command), req_bytes, req_tag);
         if (rsp_valid && rsp_ready) begin
            if (ring_wr == ring_rd) begin
               report($sformatf("unexpected response tag %0d", rsp_tag));
            end else begin
               g = grant_ring[ring_rd % RING];
               ring_rd++;
               if (rsp_tag !== g.tag)
                  report($sformatf("tag %0d, predicted %0d", rsp_tag, g.tag));
               if (rsp_status !== g.status)
                  report($sformatf("status %0d, predicted %0d", rsp_status, g.status));
               if (rsp_last !== g.last)
                  report($sformatf("last %0b, predicted %0b", rsp_last, g.last));
            end
         end
      end
   end
endmodule

// ===== tb/tb_fifo_token_bucket_shaper_unit.sv =====
// ---------------------------------------------------------------------------
// tb_fifo_token_bucket_shaper_unit
// Drives request, tick and stop words into the shaper under several refill
// settings with random idling on both channels; a checker predicts results.
// ---------------------------------------------------------------------------
module tb_fifo_token_bucket_shaper_unit;
   import ftbs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_en = 1'b0;
   logic [31:0] csr_write_data = '0;
   logic        quiet = 1'b0;
   int          failures;
   int          grants_waiting;
   int          idle_cycles = 0;

   ftbs_req_if req_chan();
   ftbs_rsp_if rsp_chan();

   fifo_token_bucket_shaper_unit dut (
      .clock(clock), .reset(reset), .csr_write_en(csr_write_en),
      .csr_write_data(csr_write_data), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   fifo_token_bucket_shaper_unit_checker checker_i (
      .clock(clock), .reset(reset), .csr_write_en(csr_write_en),
      .csr_write_data(csr_write_data),
      .req_valid(req_chan.valid), .req_ready(req_chan.ready),
      .req_command(req_chan.command), .req_bytes(req_chan.request_bytes),
      .req_tag(req_chan.request_tag),
      .rsp_valid(rsp_chan.valid), .rsp_ready(rsp_chan.ready),
      .rsp_tag(rsp_chan.grant_tag), .rsp_status(rsp_chan.grant_status),
      .rsp_last(rsp_chan.last_result),
      .failures(failures), .grants_waiting(grants_waiting)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.command = CMD_REQUEST;
      req_chan.request_bytes = '0;
      req_chan.request_tag = '0;
      rsp_chan.ready = 1'b0;
   end

   // Receiver stalls at random about 23 percent of the time, except in quiet stretches.
   always @(posedge clock) begin
      rsp_chan.ready <= quiet || ($urandom_range(99) >= 23);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_fifo_token_bucket_shaper_unit NOT OK");
         $finish;
      end
   end

   // Valid stays high after a word is taken; the next word or a drain replaces
   // or drops it in the same time step, so the taken word is never offered twice.
   task automatic send_word(input cmd_type cmd, input logic [31:0] bytes, input logic [7:0] tag);
      while (!quiet && $urandom_range(99) < 23) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.command <= cmd;
      req_chan.request_bytes <= bytes;
      req_chan.request_tag <= tag;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (grants_waiting != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_refill(input logic [31:0] amount);
      drain();
      csr_write_en <= 1'b1;
      csr_write_data <= amount;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Mostly small requests so queues form and drain; now and then extremes.
   function automatic logic [31:0] pick_bytes(input logic [31:0] amount);
      case ($urandom_range(9))
         0: return $urandom;
         1: return 32'hFFFF_FFFF;
         2: return '0;
         default: return $urandom_range(amount < 4 ? 8 : amount / 2 + 3);
      endcase
   endfunction

   task automatic random_phase(input logic [31:0] amount, input int words);
      int r;
      for (int i = 0; i < words; i++) begin
         r = $urandom_range(99);
         if (r < 65)      send_word(CMD_REQUEST, pick_bytes(amount), 8'($urandom));
         else if (r < 97) send_word(CMD_TICK, $urandom, 8'($urandom));
         else if (r < 99) send_word(CMD_STOP, $urandom, 8'($urandom));
         else             send_word(cmd_type'(2'd3), $urandom, 8'($urandom));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // Unlimited pass, then a small bucket with partial heads, a deferred refill,
      // a queue of 15 waiters, a stop that releases them and words while stopped.
      send_word(CMD_REQUEST, 32'hFFFF_FFFF, 8'hFF);
      set_refill(32'd10);
      send_word(CMD_REQUEST, 32'd4, 8'h00);
      send_word(CMD_TICK, '0, '0);
      send_word(CMD_REQUEST, 32'd25, 8'h01);
      send_word(CMD_REQUEST, 32'd2, 8'h02);
      send_word(CMD_TICK, '0, '0);
      send_word(CMD_TICK, '0, '0);
      for (int i = 0; i < 18; i++) send_word(CMD_REQUEST, 32'd3, 8'(8'h10 + i));
      send_word(CMD_TICK, '0, '0);
      send_word(cmd_type'(2'd3), 32'hFFFF_FFFF, 8'hFF);
      send_word(CMD_STOP, '0, '0);
      send_word(CMD_REQUEST, 32'd7, 8'hAA);
      send_word(CMD_TICK, '0, '0);
      drain();
      reset <= 1'b0;
      quiet <= 1'b1;
      random_phase(32'd10, 40);
      quiet <= 1'b0;
      drain();
      // Stop is permanent, so the later phases run the stopped behaviour on.
      set_refill(32'hFFFF_FFFF);
      random_phase(32'hFFFF_FFFF, 40);
      set_refill(32'd0);
      random_phase(32'd0, 20);
      set_refill(32'd100);
      random_phase(32'd100, 120);
      set_refill(32'd1);
      random_phase(32'd1, 40);
      drain();
      if (failures == 0)
         $display("tb_fifo_token_bucket_shaper_unit OK");
      else
         $display("tb_fifo_token_bucket_shaper_unit NOT OK");
      $finish;
   end
endmodule
